// ----- design/ptq_pkg.sv -----
// ---------------------------------------------------------------------------
// ptq_pkg
// shared constants, item types and cell control for the priority task queue
// ---------------------------------------------------------------------------
package ptq_pkg;

  localparam int CAPACITY      = 64;
  localparam int TAG_BITS      = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_BITS      = $clog2(CAPACITY + 1);

  // fixed widths of the item fields
  localparam int IN_TAG_W    = 16;
  localparam int IN_PRIO_W   = 16;
  localparam int OUT_TAG_W   = 16;
  localparam int OUT_PRIO_W  = 16;
  localparam int OUT_COUNT_W = 7;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_REMOVED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic                        req_type;
    logic [IN_TAG_W-1:0]         task_tag;
    logic signed [IN_PRIO_W-1:0] task_priority;
  } in_item_t;

  typedef struct packed {
    status_t                      status;
    logic [OUT_TAG_W-1:0]         removed_tag;
    logic signed [OUT_PRIO_W-1:0] removed_priority;
    logic [OUT_COUNT_W-1:0]       task_count;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic [TAG_BITS-1:0]             tag;
    logic signed [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   din;
  } cell_ctl_t;

endpackage

// ----- design/ptq_cell.sv -----
// ---------------------------------------------------------------------------
// ptq_cell
// one slot of the sorted chain: compare with the new entry, keep or take
// ---------------------------------------------------------------------------
module ptq_cell import ptq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      keep
);

  entry_t entry_r;
  entry_t entry_nxt;

  // stays put on insert when it outranks or ties the new entry
  assign keep  = occupied && (entry_r.prio >= ctl.din.prio);
  assign entry = entry_r;

  always_comb begin
    case (ctl.op)
      OP_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left_keep) begin
          entry_nxt = ctl.din;
        end else begin
          entry_nxt = left_entry;
        end
      end
      OP_SHIFT: entry_nxt = right_entry;
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/ptq_chain.sv -----
// ---------------------------------------------------------------------------
// ptq_chain
// row of cells held in priority order, oldest first among equals
// ---------------------------------------------------------------------------
module ptq_chain import ptq_pkg::*; (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [CNT_BITS-1:0] count,
  output entry_t              entries [CAPACITY]
);

  logic [CAPACITY-1:0] keeps;
  logic [CAPACITY-1:0] occupied;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic   lk;
      entry_t le;
      entry_t re;

      assign occupied[i] = (CNT_BITS'(i) < count);

      if (i == 0) begin : g_first
        assign lk = 1'b1;
        assign le = ctl.din;
      end else begin : g_mid
        assign lk = keeps[i-1];
        assign le = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign re = entries[i];
      end else begin : g_inner
        assign re = entries[i+1];
      end

      ptq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (occupied[i]),
        .left_keep   (lk),
        .left_entry  (le),
        .right_entry (re),
        .entry       (entries[i]),
        .keep        (keeps[i])
      );
    end
  endgenerate

endmodule

// ----- design/priority_task_queue_top.sv -----
// a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle; all cells compare and shift in parallel
// an item waits only while the output register holds an untaken result
// reset clears the entry count and the output valid; cell contents are
// not reset and are read only below the count
// ---------------------------------------------------------------------------
// priority_task_queue_top
// bounded priority queue with extract-max, built as a sorted chain of cells
// ---------------------------------------------------------------------------
module priority_task_queue_top import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                in_accept;
  logic                full;
  logic                empty;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_item_r;
  out_item_t           out_item_nxt;
  cell_ctl_t           ctl;
  entry_t              entries [CAPACITY];

  // output register parts the two sides: stall only while a result is stuck
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign full  = (count_r == CNT_BITS'(CAPACITY));
  assign empty = (count_r == '0);

  // cell row, head of the chain is always the next entry to leave
  ptq_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (count_r),
    .entries (entries)
  );

  always_comb begin
    // new entry, cut to the stored widths
    ctl.din.tag   = in_item.task_tag[TAG_BITS-1:0];
    ctl.din.prio  = in_item.task_priority[PRIORITY_BITS-1:0];
    ctl.op        = OP_HOLD;
    count_nxt     = count_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      out_valid_nxt                 = 1'b1;
      out_item_nxt.removed_tag      = '0;
      out_item_nxt.removed_priority = '0;
      if (in_item.req_type == REQ_ADD) begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          ctl.op              = OP_INSERT;
          count_nxt           = count_r + 1'b1;
          out_item_nxt.status = ST_ADDED;
        end
      end else begin
        if (empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          // head leaves, the rest close up towards it
          ctl.op                        = OP_SHIFT;
          count_nxt                     = count_r - 1'b1;
          out_item_nxt.status           = ST_REMOVED;
          out_item_nxt.removed_tag      = OUT_TAG_W'(entries[0].tag);
          out_item_nxt.removed_priority = OUT_PRIO_W'(entries[0].prio);
        end
      end
      out_item_nxt.task_count = OUT_COUNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.req_type == REQ_ADD && !full) |=>
      (count_r == $past(count_r) + 1'b1) && out_item_r.status == ST_ADDED)
    else $error("accepted add did not grow the queue");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.req_type == REQ_REMOVE && !empty) |=>
      (count_r == $past(count_r) - 1'b1) && out_item_r.status == ST_REMOVED)
    else $error("accepted remove did not shrink the queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_BITS'(2)) |-> (entries[0].prio >= entries[1].prio))
    else $error("head of chain outranked by its neighbour");
`endif

endmodule
